/* design/vnp_pkg.sv */
// Package with the shared types and constants of the vector norm and projection engine.
`default_nettype none

package vnp_pkg;

    localparam int ELEM_W = 16;
    localparam int ACC_W = 48;
    localparam int FRAC_W = 16;
    localparam int SRC_W = ACC_W + FRAC_W;
    localparam int REM_W = 50;
    localparam int ROOT_W = SRC_W / 2;

    localparam logic [ACC_W-1:0] S48_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] S48_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [ACC_W-1:0] U48_MAX = {ACC_W{1'b1}};

    localparam logic [5:0] SQRT_STEPS_M1 = 6'(ROOT_W - 1);
    localparam logic [5:0] DIV_STEPS_M1 = 6'(SRC_W - 1);

    localparam logic REG_MODE = 1'b0;
    localparam logic REG_USE_REF = 1'b1;

    typedef enum logic [1:0] {
        MODE_SQ_DIST,
        MODE_DIST,
        MODE_SCALAR_PROJ,
        MODE_PROJ_SCALE
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_D,
        ST_MUL_V,
        ST_MUL_UV,
        ST_ACC_DOT,
        ST_FINISH,
        ST_SQRT,
        ST_SQRT_END,
        ST_DIV,
        ST_DIV_END,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

/* design/vector_norm_projection_engine.sv */
// Vector norm and projection engine: element accumulation and shared root/divide unit.
// An element item is accepted in idle and passes MUL_D, MUL_V, MUL_UV and ACC_DOT;
// the shared 17x17 multiplier forms three products, each added into its accumulator
// in the next state. After a last item the root runs in distance mode, the root and then
// the divide in scalar projection mode and the divide in projection scale mode; one shared
// shift-and-subtract unit runs 32 root steps and 64 quotient steps.
// Reset clears the accumulators, sets mode to squared distance and enables the reference.
`default_nettype none

module vector_norm_projection_engine (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [15:0] v_elem,
    input  wire logic signed [15:0] u_elem,
    input  wire logic               last,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [47:0]      value,
    output logic                    zero_divisor
);

    vnp_pkg::state_t state_reg, state_next;
    vnp_pkg::mode_t  mode_reg;
    logic            use_ref_reg;

    logic signed [15:0] v_reg, u_reg;
    logic               last_reg;
    logic signed [33:0] prod_reg;

    logic [47:0]        diff_reg, diff_next;
    logic [47:0]        vss_reg, vss_next;
    logic signed [47:0] dot_reg, dot_next;

    logic [49:0] rem_reg, rem_next;
    logic [63:0] src_reg, src_next;
    logic [63:0] quo_reg, quo_next;
    logic [47:0] den_reg, den_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;

    logic [47:0] res_value_reg, res_value_next;
    logic        res_zero_reg, res_zero_next;

    logic        out_valid_reg, out_valid_next;
    logic [47:0] value_reg, value_next;
    logic        zero_reg, zero_next;

    logic               cfg_write;
    logic               in_accept;
    logic signed [16:0] diff_elem;
    logic signed [16:0] mul_a, mul_b;
    logic signed [33:0] mul_p;
    logic [48:0]        diff_sum, vss_sum;
    logic signed [48:0] dot_sum;
    logic [47:0]        dot_sat;
    logic [47:0]        sel_sum;
    logic [47:0]        dot_mag;
    logic               is_sqrt;
    logic [49:0]        shifted;
    logic [49:0]        sub_val;
    logic [50:0]        trial;
    logic               fits;
    logic               quo_ovf;
    logic [47:0]        div_value;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata = (paddr[2] == vnp_pkg::REG_USE_REF) ? {31'b0, use_ref_reg}
                                                        : {30'b0, mode_reg};

    assign in_ready = (state_reg == vnp_pkg::ST_IDLE);
    assign in_accept = in_valid && in_ready;

    assign out_valid = out_valid_reg;
    assign value = value_reg;
    assign zero_divisor = zero_reg;

    assign diff_elem = {v_reg[15], v_reg} - {u_reg[15], u_reg};

    always_comb
    begin
        unique case (state_reg)
            vnp_pkg::ST_MUL_D:
            begin
                mul_a = diff_elem;
                mul_b = diff_elem;
            end
            vnp_pkg::ST_MUL_V:
            begin
                mul_a = {v_reg[15], v_reg};
                mul_b = {v_reg[15], v_reg};
            end
            default:
            begin
                mul_a = {v_reg[15], v_reg};
                mul_b = {u_reg[15], u_reg};
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign diff_sum = {1'b0, diff_reg} + {16'b0, prod_reg[32:0]};
    assign vss_sum = {1'b0, vss_reg} + {16'b0, prod_reg[32:0]};
    assign dot_sum = {dot_reg[47], dot_reg} + {{15{prod_reg[33]}}, prod_reg};
    assign dot_sat = (dot_sum[48] != dot_sum[47])
                   ? (dot_sum[48] ? vnp_pkg::S48_MIN : vnp_pkg::S48_MAX)
                   : dot_sum[47:0];

    assign sel_sum = use_ref_reg ? diff_reg : vss_reg;
    assign dot_mag = dot_reg[47] ? (~dot_reg + 48'd1) : dot_reg;

    assign is_sqrt = (state_reg == vnp_pkg::ST_SQRT);
    assign shifted = is_sqrt ? {rem_reg[47:0], src_reg[63:62]} : {rem_reg[48:0], src_reg[63]};
    assign sub_val = is_sqrt ? {16'b0, quo_reg[31:0], 2'b01} : {2'b0, den_reg};
    assign trial = {1'b0, shifted} - {1'b0, sub_val};
    assign fits = !trial[50];

    assign quo_ovf = |quo_reg[63:47];
    assign div_value = neg_reg ? (quo_ovf ? vnp_pkg::S48_MIN : (~quo_reg[47:0] + 48'd1))
                               : (quo_ovf ? vnp_pkg::S48_MAX : quo_reg[47:0]);

    always_comb
    begin
        state_next = state_reg;
        diff_next = diff_reg;
        vss_next = vss_reg;
        dot_next = dot_reg;
        rem_next = rem_reg;
        src_next = src_reg;
        quo_next = quo_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        res_value_next = res_value_reg;
        res_zero_next = res_zero_reg;
        out_valid_next = out_valid_reg && !out_ready;
        value_next = value_reg;
        zero_next = zero_reg;

        unique case (state_reg)
            vnp_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = vnp_pkg::ST_MUL_D;
                end
            end
            vnp_pkg::ST_MUL_D:
            begin
                state_next = vnp_pkg::ST_MUL_V;
            end
            vnp_pkg::ST_MUL_V:
            begin
                diff_next = diff_sum[48] ? vnp_pkg::U48_MAX : diff_sum[47:0];
                state_next = vnp_pkg::ST_MUL_UV;
            end
            vnp_pkg::ST_MUL_UV:
            begin
                vss_next = vss_sum[48] ? vnp_pkg::U48_MAX : vss_sum[47:0];
                state_next = vnp_pkg::ST_ACC_DOT;
            end
            vnp_pkg::ST_ACC_DOT:
            begin
                dot_next = dot_sat;
                state_next = last_reg ? vnp_pkg::ST_FINISH : vnp_pkg::ST_IDLE;
            end
            vnp_pkg::ST_FINISH:
            begin
                rem_next = '0;
                quo_next = '0;
                neg_next = dot_reg[47];
                res_zero_next = 1'b0;
                res_value_next = '0;
                unique case (mode_reg)
                    vnp_pkg::MODE_SQ_DIST:
                    begin
                        res_value_next = sel_sum[47] ? vnp_pkg::S48_MAX : sel_sum;
                        state_next = vnp_pkg::ST_OUT;
                    end
                    vnp_pkg::MODE_DIST:
                    begin
                        src_next = {sel_sum, 16'b0};
                        cnt_next = vnp_pkg::SQRT_STEPS_M1;
                        state_next = vnp_pkg::ST_SQRT;
                    end
                    vnp_pkg::MODE_SCALAR_PROJ:
                    begin
                        src_next = {vss_reg, 16'b0};
                        cnt_next = vnp_pkg::SQRT_STEPS_M1;
                        state_next = vnp_pkg::ST_SQRT;
                    end
                    vnp_pkg::MODE_PROJ_SCALE:
                    begin
                        if (vss_reg == '0)
                        begin
                            res_zero_next = 1'b1;
                            state_next = vnp_pkg::ST_OUT;
                        end
                        else
                        begin
                            src_next = {dot_mag, 16'b0};
                            den_next = vss_reg;
                            cnt_next = vnp_pkg::DIV_STEPS_M1;
                            state_next = vnp_pkg::ST_DIV;
                        end
                    end
                endcase
            end
            vnp_pkg::ST_SQRT:
            begin
                rem_next = fits ? trial[49:0] : shifted;
                quo_next = {quo_reg[62:0], fits};
                src_next = {src_reg[61:0], 2'b00};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == '0)
                begin
                    state_next = vnp_pkg::ST_SQRT_END;
                end
            end
            vnp_pkg::ST_SQRT_END:
            begin
                if (mode_reg == vnp_pkg::MODE_DIST)
                begin
                    res_value_next = {16'b0, quo_reg[31:0]};
                    state_next = vnp_pkg::ST_OUT;
                end
                else if (quo_reg[31:0] == '0)
                begin
                    res_zero_next = 1'b1;
                    state_next = vnp_pkg::ST_OUT;
                end
                else
                begin
                    rem_next = '0;
                    src_next = {dot_mag, 16'b0};
                    den_next = {16'b0, quo_reg[31:0]};
                    quo_next = '0;
                    cnt_next = vnp_pkg::DIV_STEPS_M1;
                    state_next = vnp_pkg::ST_DIV;
                end
            end
            vnp_pkg::ST_DIV:
            begin
                rem_next = fits ? trial[49:0] : shifted;
                quo_next = {quo_reg[62:0], fits};
                src_next = {src_reg[62:0], 1'b0};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == '0)
                begin
                    state_next = vnp_pkg::ST_DIV_END;
                end
            end
            vnp_pkg::ST_DIV_END:
            begin
                res_value_next = div_value;
                state_next = vnp_pkg::ST_OUT;
            end
            vnp_pkg::ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    value_next = res_value_reg;
                    zero_next = res_zero_reg;
                    diff_next = '0;
                    vss_next = '0;
                    dot_next = '0;
                    state_next = vnp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = vnp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vnp_pkg::ST_IDLE;
            mode_reg <= vnp_pkg::MODE_SQ_DIST;
            use_ref_reg <= 1'b1;
            diff_reg <= '0;
            vss_reg <= '0;
            dot_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            diff_reg <= diff_next;
            vss_reg <= vss_next;
            dot_reg <= dot_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                if (paddr[2] == vnp_pkg::REG_MODE)
                begin
                    mode_reg <= vnp_pkg::mode_t'(pwdata[1:0]);
                end
                else
                begin
                    use_ref_reg <= pwdata[0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            v_reg <= v_elem;
            u_reg <= u_elem;
            last_reg <= last;
        end
        prod_reg <= mul_p;
        rem_reg <= rem_next;
        src_reg <= src_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
        res_value_reg <= res_value_next;
        res_zero_reg <= res_zero_next;
        value_reg <= value_next;
        zero_reg <= zero_next;
    end

    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_divisor |-> value == '0)
        else $error("zero divisor result carries a nonzero value");

    a_zero_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_divisor |->
            (mode_reg == vnp_pkg::MODE_SCALAR_PROJ || mode_reg == vnp_pkg::MODE_PROJ_SCALE))
        else $error("zero divisor flag raised in a distance mode");

    a_dist_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (mode_reg == vnp_pkg::MODE_SQ_DIST || mode_reg == vnp_pkg::MODE_DIST)
            |-> !value[47])
        else $error("distance result is negative");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while the previous item is still in the multiplier");

endmodule

`default_nettype wire
